FILE: design/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared constants, types and precedence tables of the infix to postfix core
// ----------------------------------------------------------------------------
package itp_pkg;

    localparam int ITP_STACK_DEPTH = 32;

    typedef logic [7:0] t_sym;
    // precedence biased by one so that the lowest rank (-1) maps to zero
    typedef logic [3:0] t_rank;

    localparam t_sym CH_HASH    = 8'h23;
    localparam t_sym CH_DOLLAR  = 8'h24;
    localparam t_sym CH_PERCENT = 8'h25;
    localparam t_sym CH_LPAREN  = 8'h28;
    localparam t_sym CH_RPAREN  = 8'h29;
    localparam t_sym CH_STAR    = 8'h2A;
    localparam t_sym CH_PLUS    = 8'h2B;
    localparam t_sym CH_MINUS   = 8'h2D;
    localparam t_sym CH_SLASH   = 8'h2F;
    localparam t_sym CH_CARET   = 8'h5E;

    // rank of an entry sitting on the stack
    function automatic t_rank stack_rank(input t_sym c);
        t_rank r;
        case (c)
            CH_PLUS, CH_MINUS:              r = 4'd3;
            CH_STAR, CH_SLASH, CH_PERCENT:  r = 4'd5;
            CH_CARET, CH_DOLLAR:            r = 4'd6;
            CH_LPAREN:                      r = 4'd1;
            CH_HASH:                        r = 4'd0;
            default:                        r = 4'd9;
        endcase
        return r;
    endfunction

    // rank of an incoming symbol
    function automatic t_rank input_rank(input t_sym c);
        t_rank r;
        case (c)
            CH_PLUS, CH_MINUS:              r = 4'd2;
            CH_STAR, CH_SLASH, CH_PERCENT:  r = 4'd4;
            CH_CARET, CH_DOLLAR:            r = 4'd7;
            CH_LPAREN:                      r = 4'd10;
            CH_RPAREN:                      r = 4'd1;
            default:                        r = 4'd8;
        endcase
        return r;
    endfunction

endpackage

FILE: design/itp_if.sv
// ----------------------------------------------------------------------------
// itp_if
// valid/ready channels for infix characters and postfix results
// ----------------------------------------------------------------------------
interface itp_in_if
    import itp_pkg::*;
();
    logic valid;
    logic ready;
    t_sym in_symbol;
    logic in_last;

    modport source (output valid, output in_symbol, output in_last, input ready);
    modport sink   (input valid, input in_symbol, input in_last, output ready);
endinterface

interface itp_out_if
    import itp_pkg::*;
();
    logic valid;
    logic ready;
    t_sym out_symbol;
    logic is_symbol;
    logic overflow;
    logic run_end;

    modport source (output valid, output out_symbol, output is_symbol,
                    output overflow, output run_end, input ready);
    modport sink   (input valid, input out_symbol, input is_symbol,
                    input overflow, input run_end, output ready);
endinterface

FILE: design/itp_stack_mem.sv
// ----------------------------------------------------------------------------
// itp_stack_mem
// operator stack storage, one write port and one registered read port
// ----------------------------------------------------------------------------
module itp_stack_mem
    import itp_pkg::*;
#(
    parameter int DEPTH = ITP_STACK_DEPTH,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wr_addr,
    input  t_sym          i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output t_sym          o_rd_data
);

    t_sym r_mem [DEPTH];
    t_sym r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: design/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core
// operator-precedence infix to postfix converter with a memory-held stack
// ----------------------------------------------------------------------------
// a request is evaluated in the cycle after it is taken; each popped operator
//   takes a compare step and an emit step, a discarded pair an extra refill step
// a new request is taken only in idle, after the last one is done; the end marker
//   adds a flush step; the single read port of the stack memory paces the pops
// reset: synchronous, active low; stack empty, overflow flag clear, no result
//   pending; stack memory contents are not cleared
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core
    import itp_pkg::*;
#(
    parameter int STACK_DEPTH = ITP_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    itp_in_if.sink      i_in,
    itp_out_if.source   o_out
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;  // waiting for a request
    localparam logic [2:0] S_EVAL   = 3'd1;  // compare top against request
    localparam logic [2:0] S_POP    = 3'd2;  // emit top, next top from memory
    localparam logic [2:0] S_REFILL = 3'd3;  // matched pair dropped, reload top
    localparam logic [2:0] S_FLUSH  = 3'd4;  // drain stack, then end marker

    // control state
    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic          r_flush, n_flush;
    logic          r_out_valid, n_out_valid;

    // payload state
    t_sym          r_top, n_top;      // cached copy of the top entry
    t_sym          r_sym, n_sym;
    logic          r_last, n_last;
    t_rank         r_grank, n_grank;
    t_sym          r_out_symbol, n_out_symbol;
    logic          r_out_is_sym, n_out_is_sym;
    logic          r_out_ovf, n_out_ovf;
    logic          r_out_end, n_out_end;

    // memory port
    logic          mem_we;
    logic [AW-1:0] mem_wr_addr;
    logic [AW-1:0] mem_rd_addr;
    t_sym          mem_rd_data;

    logic          slot_free;
    logic          stack_empty;
    t_rank         top_rank;
    logic          pop_final;

    // the read port always looks at the entry just below the top, so the
    // new top is ready in the cycle after the count settles; the only write
    // goes to the slot above the top and never hits that address
    assign mem_wr_addr = r_count[AW-1:0];
    assign mem_rd_addr = AW'(r_count - CW'(2));

    itp_stack_mem #(
        .DEPTH (STACK_DEPTH),
        .AW    (AW)
    ) u_stack_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (r_sym),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    assign slot_free   = !r_out_valid || o_out.ready;
    assign stack_empty = (r_count == '0);
    assign top_rank    = stack_rank(r_top);

    // a pop closes the run when the pop loop stops after it and no flush follows
    assign pop_final = !r_last &&
                       ((r_count == CW'(1)) || (stack_rank(mem_rd_data) <= r_grank));

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_flush      = r_flush;
        n_top        = r_top;
        n_sym        = r_sym;
        n_last       = r_last;
        n_grank      = r_grank;
        n_out_valid  = r_out_valid;
        n_out_symbol = r_out_symbol;
        n_out_is_sym = r_out_is_sym;
        n_out_ovf    = r_out_ovf;
        n_out_end    = r_out_end;
        mem_we       = 1'b0;

        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_sym   = i_in.in_symbol;
                    n_last  = i_in.in_last;
                    n_grank = input_rank(i_in.in_symbol);
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (!stack_empty && (top_rank > r_grank)) begin
                    n_state = S_POP;
                end else if (!stack_empty && (top_rank == r_grank)) begin
                    // matched pair: drop both
                    n_count = r_count - CW'(1);
                    n_state = S_REFILL;
                end else begin
                    if (r_count == CW'(STACK_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_we  = 1'b1;
                        n_top   = r_sym;
                        n_count = r_count + CW'(1);
                    end
                    n_flush = r_last;
                    n_state = r_last ? S_FLUSH : S_IDLE;
                end
            end
            S_REFILL: begin
                n_top   = mem_rd_data;
                n_flush = r_last;
                n_state = r_last ? S_FLUSH : S_IDLE;
            end
            S_POP: begin
                if (slot_free) begin
                    n_out_valid  = 1'b1;
                    n_out_symbol = r_top;
                    n_out_is_sym = 1'b1;
                    n_out_ovf    = r_ovf;
                    n_out_end    = pop_final;
                    n_top        = mem_rd_data;
                    n_count      = r_count - CW'(1);
                    n_state      = r_flush ? S_FLUSH : S_EVAL;
                end
            end
            S_FLUSH: begin
                if (!stack_empty) begin
                    n_state = S_POP;
                end else if (slot_free) begin
                    // end marker closes the expression
                    n_out_valid  = 1'b1;
                    n_out_symbol = '0;
                    n_out_is_sym = 1'b0;
                    n_out_ovf    = r_ovf;
                    n_out_end    = 1'b1;
                    n_ovf        = 1'b0;
                    n_flush      = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_flush     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_flush     <= n_flush;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top        <= n_top;
        r_sym        <= n_sym;
        r_last       <= n_last;
        r_grank      <= n_grank;
        r_out_symbol <= n_out_symbol;
        r_out_is_sym <= n_out_is_sym;
        r_out_ovf    <= n_out_ovf;
        r_out_end    <= n_out_end;
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.out_symbol = r_out_symbol;
    assign o_out.is_symbol  = r_out_is_sym;
    assign o_out.overflow   = r_out_ovf;
    assign o_out.run_end    = r_out_end;

    // stack never grows past its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(STACK_DEPTH))
        else $error("stack count exceeds depth");

    // a flush never survives into idle
    a_flush_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_flush)
        else $error("flush pending while idle");

    // end marker leaves an empty stack and a clear overflow flag
    a_end_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && stack_empty && slot_free)
        |=> (r_state == S_IDLE && stack_empty && !r_ovf && r_out_valid && r_out_end))
        else $error("end of expression left state behind");

endmodule
